FILE: hw/rtl/owtp_pkg.sv
// Package: per-bus entry layout, phase codes, timing constants and field widths.
`timescale 1ns / 1ps
package owtp_pkg;

  localparam int NUM_BUSES_DEF = 2;

  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 20;
  localparam int TIMER_W = 20;
  localparam int TEMP_W = 12;

  localparam logic [CFG_IDX_W-1:0] REG_CONV_WAIT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RESET_LOW = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PRES_SAMPLE = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RESET_TAIL = 2'd3;

  localparam logic [19:0] CONV_WAIT_RST = 20'd200000;
  localparam logic [9:0] RESET_LOW_RST = 10'd485;
  localparam logic [7:0] PRES_SAMPLE_RST = 8'd70;
  localparam logic [9:0] RESET_TAIL_RST = 10'd440;

  localparam logic [7:0] CMD_SKIP = 8'hCC;
  localparam logic [7:0] CMD_CONVERT = 8'h44;
  localparam logic [7:0] CMD_READ = 8'hBE;
  localparam logic [7:0] BYTE_ALL_ONES = 8'hFF;

  localparam logic [TIMER_W-1:0] WSLOT_LAST = 20'd91;
  localparam logic [TIMER_W-1:0] WZERO_LOW = 20'd90;
  localparam logic [TIMER_W-1:0] WONE_LOW = 20'd1;
  localparam logic [TIMER_W-1:0] RSLOT_LAST = 20'd75;
  localparam logic [TIMER_W-1:0] RLOW_FIRST = 20'd1;
  localparam logic [TIMER_W-1:0] RLOW_END = 20'd6;
  localparam logic [TIMER_W-1:0] RSAMPLE = 20'd21;

  typedef enum logic [3:0] {
    PH_R1_LOW = 4'd0,
    PH_R1_PRES = 4'd1,
    PH_R1_TAIL = 4'd2,
    PH_W1_SKIP = 4'd3,
    PH_W_CONV = 4'd4,
    PH_CONV_WAIT = 4'd5,
    PH_R2_LOW = 4'd6,
    PH_R2_PRES = 4'd7,
    PH_R2_TAIL = 4'd8,
    PH_W2_SKIP = 4'd9,
    PH_W_READ = 4'd10,
    PH_RD_LO = 4'd11,
    PH_RD_HI = 4'd12
  } phase_t;

  typedef struct packed {
    phase_t phase;
    logic [TIMER_W-1:0] timer;
    logic [2:0] bit_count;
    logic [7:0] shift_byte;
    logic [7:0] low_byte;
    logic rd_valid;
    logic [TEMP_W-1:0] rd_value;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic [19:0] conv_wait;
    logic [9:0] reset_low;
    logic [7:0] pres_sample;
    logic [9:0] reset_tail;
  } cfg_t;

  typedef struct packed {
    logic drive_low;
    logic reading_done;
  } step_flags_t;

  function automatic entry_t go_phase(entry_t s, phase_t ph, logic [7:0] load);
    entry_t n;
    n = s;
    n.phase = ph;
    n.timer = '0;
    n.bit_count = '0;
    n.shift_byte = load;
    return n;
  endfunction

endpackage

FILE: hw/rtl/owtp_in_if.sv
// Interface: input request channel (bus tick and sampled line level).
`timescale 1ns / 1ps
interface owtp_in_if;
  logic valid;
  logic ready;
  logic bus;
  logic line_level;
  modport source(output valid, output bus, output line_level, input ready);
  modport sink(input valid, input bus, input line_level, output ready);
endinterface

FILE: hw/rtl/owtp_out_if.sv
// Interface: result request channel.
`timescale 1ns / 1ps
interface owtp_out_if;
  logic valid;
  logic ready;
  logic drive_low;
  logic reading_done;
  logic reading_valid;
  logic [11:0] temp_value;
  modport source(output valid, output drive_low, output reading_done,
                 output reading_valid, output temp_value, input ready);
  modport sink(input valid, input drive_low, input reading_done,
               input reading_valid, input temp_value, output ready);
endinterface

FILE: hw/rtl/onewire_temp_sensor_poller_core.sv
// Top level: per-bus state RAM, read-modify-write stage, result register.
// Stage one registers a request with its RAM read, then the result register.
// Throughput: one request per cycle while the output is not stalled, also on
// the same bus back to back; the single read and write ports of the RAM set it.
// Reset: rst (synchronous) clears the registers to defaults and marks every
// bus entry as not written, which reads as phase zero with no reading.
`timescale 1ns / 1ps
module onewire_temp_sensor_poller_core #(
  parameter int NUM_BUSES = owtp_pkg::NUM_BUSES_DEF
) (
  input  logic clk,
  input  logic rst,
  owtp_in_if.sink in_ch,
  owtp_out_if.source out_ch,
  input  logic cfg_we,
  input  logic [owtp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [owtp_pkg::CFG_DATA_W-1:0] cfg_data
);
  localparam int AW = (NUM_BUSES > 1) ? $clog2(NUM_BUSES) : 1;

  owtp_pkg::cfg_t cfg;
  logic [NUM_BUSES-1:0] entry_valid;

  logic s1_valid, s1_bus, s1_lvl, s1_hit, s1_ent_valid;
  logic [AW-1:0] s1_addr;
  logic [owtp_pkg::ENTRY_W-1:0] ram_rd, fwd_data;

  owtp_pkg::entry_t cur, nxt;
  owtp_pkg::step_flags_t flags;

  logic accept, advance, in_range, wr_en;
  logic [AW-1:0] rd_addr;

  logic out_valid, o_drive, o_done, o_rvalid;
  logic [owtp_pkg::TEMP_W-1:0] o_temp;

  assign advance = s1_valid && (!out_valid || out_ch.ready);
  assign in_ch.ready = !s1_valid || advance;
  assign accept = in_ch.valid && in_ch.ready;
  assign rd_addr = AW'(in_ch.bus);
  assign in_range = 32'(s1_bus) < NUM_BUSES;
  assign wr_en = advance && in_range;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.conv_wait <= owtp_pkg::CONV_WAIT_RST;
      cfg.reset_low <= owtp_pkg::RESET_LOW_RST;
      cfg.pres_sample <= owtp_pkg::PRES_SAMPLE_RST;
      cfg.reset_tail <= owtp_pkg::RESET_TAIL_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        owtp_pkg::REG_CONV_WAIT: cfg.conv_wait <= cfg_data;
        owtp_pkg::REG_RESET_LOW: cfg.reset_low <= cfg_data[9:0];
        owtp_pkg::REG_PRES_SAMPLE: cfg.pres_sample <= cfg_data[7:0];
        owtp_pkg::REG_RESET_TAIL: cfg.reset_tail <= cfg_data[9:0];
        default: ;
      endcase
    end
  end

  owtp_ram #(
    .WIDTH(owtp_pkg::ENTRY_W),
    .DEPTH(NUM_BUSES),
    .AW(AW)
  ) u_state_ram (
    .clk(clk),
    .wr_en(wr_en),
    .wr_addr(s1_addr),
    .wr_data(nxt),
    .rd_en(accept),
    .rd_addr(rd_addr),
    .rd_data(ram_rd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      entry_valid <= '0;
    end else begin
      if (accept) begin
        s1_valid <= 1'b1;
      end else if (advance) begin
        s1_valid <= 1'b0;
      end
      if (wr_en) begin
        entry_valid[s1_addr] <= 1'b1;
      end
    end
  end

  // same-bus write in the cycle of the read: forward the written entry
  always_ff @(posedge clk) begin
    if (wr_en) begin
      fwd_data <= nxt;
    end
    if (accept) begin
      s1_bus <= in_ch.bus;
      s1_lvl <= in_ch.line_level;
      s1_addr <= rd_addr;
      s1_hit <= wr_en && (s1_addr == rd_addr);
      s1_ent_valid <= entry_valid[rd_addr] || (wr_en && (s1_addr == rd_addr));
    end
  end

  assign cur = s1_hit ? owtp_pkg::entry_t'(fwd_data)
             : (s1_ent_valid ? owtp_pkg::entry_t'(ram_rd) : '0);

  owtp_step u_step (
    .cur(cur),
    .line_level(s1_lvl),
    .cfg(cfg),
    .nxt(nxt),
    .flags(flags)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      o_drive <= in_range && flags.drive_low;
      o_done <= in_range && flags.reading_done;
      o_rvalid <= in_range && nxt.rd_valid;
      o_temp <= in_range ? nxt.rd_value : '0;
    end
  end

  assign out_ch.valid = out_valid;
  assign out_ch.drive_low = o_drive;
  assign out_ch.reading_done = o_done;
  assign out_ch.reading_valid = o_rvalid;
  assign out_ch.temp_value = o_temp;

`ifndef ASSERT_OFF
  a_temp_zero_when_invalid: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !o_rvalid) |-> (o_temp == '0))
    else $error("temp_value nonzero with invalid reading");

  a_stage_holds: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !advance) |=> (s1_valid && $stable(s1_addr)))
    else $error("stage one lost a stalled request");

  a_done_releases: assert property (@(posedge clk) disable iff (rst)
    (out_valid && o_done) |-> !o_drive)
    else $error("bus driven on a tick that ends a reading");

  a_write_needs_stage: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> (s1_valid && !(accept && !advance)))
    else $error("state write without a request in stage one");
`endif
endmodule

FILE: hw/rtl/owtp_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module owtp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2,
  parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic clk,
  input  logic wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [WIDTH-1:0] rd_data
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end
endmodule

FILE: hw/rtl/owtp_step.sv
// Per-bus sequencer step: next entry and tick outputs from current entry.
`timescale 1ns / 1ps
module owtp_step (
  input  owtp_pkg::entry_t cur,
  input  logic line_level,
  input  owtp_pkg::cfg_t cfg,
  output owtp_pkg::entry_t nxt,
  output owtp_pkg::step_flags_t flags
);
  logic [owtp_pkg::TIMER_W-1:0] t;
  logic [owtp_pkg::TIMER_W:0] t_inc;
  logic [owtp_pkg::TIMER_W-1:0] tail_at;
  logic [7:0] sh;

  always_comb begin
    t = cur.timer;
    t_inc = {1'b0, t} + 21'd1;
    tail_at = 20'({2'b0, cfg.pres_sample} + {1'b0, cfg.reset_tail});
    sh = cur.shift_byte;
    nxt = cur;
    flags = '0;
    case (cur.phase)
      owtp_pkg::PH_R1_LOW, owtp_pkg::PH_R2_LOW: begin
        flags.drive_low = 1'b1;
        if (t_inc >= {11'd0, cfg.reset_low}) begin
          nxt = owtp_pkg::go_phase(cur, owtp_pkg::phase_t'(cur.phase + 4'd1), 8'd0);
        end else begin
          nxt.timer = t_inc[owtp_pkg::TIMER_W-1:0];
        end
      end
      owtp_pkg::PH_R1_PRES, owtp_pkg::PH_R2_PRES: begin
        nxt.timer = t_inc[owtp_pkg::TIMER_W-1:0];
        if (t >= {12'd0, cfg.pres_sample}) begin
          if (line_level) begin
            nxt = owtp_pkg::go_phase(cur, owtp_pkg::PH_R1_LOW, 8'd0);
            nxt.rd_valid = 1'b0;
            nxt.rd_value = '0;
            flags.reading_done = 1'b1;
          end else begin
            nxt.phase = owtp_pkg::phase_t'(cur.phase + 4'd1);
          end
        end
      end
      owtp_pkg::PH_R1_TAIL, owtp_pkg::PH_R2_TAIL: begin
        nxt.timer = t_inc[owtp_pkg::TIMER_W-1:0];
        if (t >= tail_at) begin
          if (!line_level) begin
            nxt = owtp_pkg::go_phase(cur, owtp_pkg::PH_R1_LOW, 8'd0);
            nxt.rd_valid = 1'b0;
            nxt.rd_value = '0;
            flags.reading_done = 1'b1;
          end else begin
            nxt = owtp_pkg::go_phase(cur, owtp_pkg::phase_t'(cur.phase + 4'd1),
                                     owtp_pkg::CMD_SKIP);
          end
        end
      end
      owtp_pkg::PH_W1_SKIP, owtp_pkg::PH_W_CONV, owtp_pkg::PH_W2_SKIP,
      owtp_pkg::PH_W_READ: begin
        flags.drive_low = cur.shift_byte[0] ? (t < owtp_pkg::WONE_LOW)
                                            : (t < owtp_pkg::WZERO_LOW);
        nxt.timer = t_inc[owtp_pkg::TIMER_W-1:0];
        if (t >= owtp_pkg::WSLOT_LAST) begin
          if (cur.bit_count == 3'd7) begin
            case (cur.phase)
              owtp_pkg::PH_W1_SKIP:
                nxt = owtp_pkg::go_phase(cur, owtp_pkg::PH_W_CONV, owtp_pkg::CMD_CONVERT);
              owtp_pkg::PH_W_CONV:
                nxt = owtp_pkg::go_phase(cur, owtp_pkg::PH_CONV_WAIT, 8'd0);
              owtp_pkg::PH_W2_SKIP:
                nxt = owtp_pkg::go_phase(cur, owtp_pkg::PH_W_READ, owtp_pkg::CMD_READ);
              default:
                nxt = owtp_pkg::go_phase(cur, owtp_pkg::PH_RD_LO, 8'd0);
            endcase
          end else begin
            nxt.shift_byte = {1'b0, cur.shift_byte[7:1]};
            nxt.bit_count = cur.bit_count + 3'd1;
            nxt.timer = '0;
          end
        end
      end
      owtp_pkg::PH_CONV_WAIT: begin
        if (t_inc >= {1'b0, cfg.conv_wait}) begin
          nxt = owtp_pkg::go_phase(cur, owtp_pkg::PH_R2_LOW, 8'd0);
        end else begin
          nxt.timer = t_inc[owtp_pkg::TIMER_W-1:0];
        end
      end
      owtp_pkg::PH_RD_LO, owtp_pkg::PH_RD_HI: begin
        flags.drive_low = (t >= owtp_pkg::RLOW_FIRST) && (t < owtp_pkg::RLOW_END);
        if (t == owtp_pkg::RSAMPLE) begin
          sh = {line_level, cur.shift_byte[7:1]};
        end
        nxt.shift_byte = sh;
        nxt.timer = t_inc[owtp_pkg::TIMER_W-1:0];
        if (t >= owtp_pkg::RSLOT_LAST) begin
          if (cur.bit_count == 3'd7) begin
            if (cur.phase == owtp_pkg::PH_RD_LO) begin
              nxt = owtp_pkg::go_phase(cur, owtp_pkg::PH_RD_HI, 8'd0);
              nxt.low_byte = sh;
            end else begin
              nxt = owtp_pkg::go_phase(cur, owtp_pkg::PH_R1_LOW, 8'd0);
              flags.reading_done = 1'b1;
              if (cur.low_byte == owtp_pkg::BYTE_ALL_ONES && sh == owtp_pkg::BYTE_ALL_ONES) begin
                nxt.rd_valid = 1'b0;
                nxt.rd_value = '0;
              end else begin
                nxt.rd_valid = 1'b1;
                nxt.rd_value = {sh, cur.low_byte[7:4]};
              end
            end
          end else begin
            nxt.bit_count = cur.bit_count + 3'd1;
            nxt.timer = '0;
          end
        end
      end
      default: begin
        nxt = owtp_pkg::go_phase(cur, owtp_pkg::PH_R1_LOW, 8'd0);
      end
    endcase
  end
endmodule

FILE: sim/tb.sv
// Testbench for onewire_temp_sensor_poller_core: per-bus 1-Wire poll sequence checked per tick.
`timescale 1ns / 1ps
module tb;

  typedef struct packed {
    logic drive_low;
    logic reading_done;
    logic reading_valid;
    logic [owtp_pkg::TEMP_W-1:0] temp_value;
  } tick_res_t;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [owtp_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [owtp_pkg::CFG_DATA_W-1:0] cfg_data;

  owtp_in_if in_ch();
  owtp_out_if out_ch();

  onewire_temp_sensor_poller_core u_top (
    .clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // bus state mirror
  owtp_pkg::phase_t bus_phase [2];
  logic [owtp_pkg::TIMER_W-1:0] bus_timer [2];
  logic [2:0] bus_bits [2];
  logic [7:0] bus_shift [2];
  logic [7:0] bus_low [2];
  logic bus_rd_valid [2];
  logic [owtp_pkg::TEMP_W-1:0] bus_rd_value [2];
  logic all_ones_read [2];
  int readings_done [2];
  owtp_pkg::cfg_t cfg;

  tick_res_t expected_ticks[$];
  int errors;
  bit idle_on;
  int rx_hold;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("FAIL onewire_temp_sensor_poller_core");
    $finish;
  end

  function automatic void enter_phase(int b, owtp_pkg::phase_t ph, logic [7:0] load);
    bus_phase[b] = ph;
    bus_timer[b] = '0;
    bus_bits[b] = '0;
    bus_shift[b] = load;
  endfunction

  function automatic tick_res_t poll_tick(int b, logic lvl);
    tick_res_t r;
    int t;
    logic [15:0] raw;
    r = '0;
    t = int'(bus_timer[b]);
    case (bus_phase[b])
      owtp_pkg::PH_R1_LOW, owtp_pkg::PH_R2_LOW: begin
        r.drive_low = 1;
        if (t + 1 >= cfg.reset_low)
          enter_phase(b, owtp_pkg::phase_t'(bus_phase[b] + 4'd1), 8'h00);
        else bus_timer[b] = 20'(t + 1);
      end
      owtp_pkg::PH_R1_PRES, owtp_pkg::PH_R2_PRES: begin
        if (t >= cfg.pres_sample && lvl) begin
          bus_rd_valid[b] = 0; bus_rd_value[b] = '0; r.reading_done = 1;
          enter_phase(b, owtp_pkg::PH_R1_LOW, 8'h00);
        end else begin
          if (t >= cfg.pres_sample)
            bus_phase[b] = owtp_pkg::phase_t'(bus_phase[b] + 4'd1);
          bus_timer[b] = 20'(t + 1);
        end
      end
      owtp_pkg::PH_R1_TAIL, owtp_pkg::PH_R2_TAIL: begin
        if (t >= int'(cfg.pres_sample) + int'(cfg.reset_tail)) begin
          if (!lvl) begin
            bus_rd_valid[b] = 0; bus_rd_value[b] = '0; r.reading_done = 1;
            enter_phase(b, owtp_pkg::PH_R1_LOW, 8'h00);
          end else begin
            enter_phase(b, owtp_pkg::phase_t'(bus_phase[b] + 4'd1), owtp_pkg::CMD_SKIP);
          end
        end else begin
          bus_timer[b] = 20'(t + 1);
        end
      end
      owtp_pkg::PH_W1_SKIP, owtp_pkg::PH_W_CONV, owtp_pkg::PH_W2_SKIP,
      owtp_pkg::PH_W_READ: begin
        r.drive_low = bus_shift[b][0] ? (t < owtp_pkg::WONE_LOW) : (t < owtp_pkg::WZERO_LOW);
        if (t >= owtp_pkg::WSLOT_LAST) begin
          bus_shift[b] = bus_shift[b] >> 1;
          if (bus_bits[b] == 3'd7) begin
            case (bus_phase[b])
              owtp_pkg::PH_W1_SKIP:
                enter_phase(b, owtp_pkg::PH_W_CONV, owtp_pkg::CMD_CONVERT);
              owtp_pkg::PH_W_CONV: enter_phase(b, owtp_pkg::PH_CONV_WAIT, 8'h00);
              owtp_pkg::PH_W2_SKIP:
                enter_phase(b, owtp_pkg::PH_W_READ, owtp_pkg::CMD_READ);
              default: enter_phase(b, owtp_pkg::PH_RD_LO, 8'h00);
            endcase
          end else begin
            bus_bits[b]++;
            bus_timer[b] = '0;
          end
        end else begin
          bus_timer[b] = 20'(t + 1);
        end
      end
      owtp_pkg::PH_CONV_WAIT: begin
        if (t + 1 >= cfg.conv_wait) enter_phase(b, owtp_pkg::PH_R2_LOW, 8'h00);
        else bus_timer[b] = 20'(t + 1);
      end
      owtp_pkg::PH_RD_LO, owtp_pkg::PH_RD_HI: begin
        r.drive_low = (t >= owtp_pkg::RLOW_FIRST && t < owtp_pkg::RLOW_END);
        if (t == owtp_pkg::RSAMPLE) bus_shift[b] = {lvl, bus_shift[b][7:1]};
        if (t >= owtp_pkg::RSLOT_LAST) begin
          if (bus_bits[b] == 3'd7) begin
            if (bus_phase[b] == owtp_pkg::PH_RD_LO) begin
              bus_low[b] = bus_shift[b];
              enter_phase(b, owtp_pkg::PH_RD_HI, 8'h00);
            end else begin
              raw = {bus_shift[b], bus_low[b]};
              bus_rd_valid[b] = !(raw == {owtp_pkg::BYTE_ALL_ONES, owtp_pkg::BYTE_ALL_ONES});
              bus_rd_value[b] = bus_rd_valid[b] ? raw[15:4] : '0;
              r.reading_done = 1;
              enter_phase(b, owtp_pkg::PH_R1_LOW, 8'h00);
            end
          end else begin
            bus_bits[b]++;
            bus_timer[b] = '0;
          end
        end else begin
          bus_timer[b] = 20'(t + 1);
        end
      end
      default: enter_phase(b, owtp_pkg::PH_R1_LOW, 8'h00);
    endcase
    if (r.reading_done) readings_done[b]++;
    r.reading_valid = bus_rd_valid[b];
    r.temp_value = bus_rd_value[b];
    return r;
  endfunction

  // line level that mostly follows a healthy sensor
  function automatic logic sensor_level(int b);
    int t;
    t = int'(bus_timer[b]);
    case (bus_phase[b])
      owtp_pkg::PH_R1_PRES, owtp_pkg::PH_R2_PRES:
        if (t >= cfg.pres_sample) return ($urandom_range(0, 9) == 0);
      owtp_pkg::PH_R1_TAIL, owtp_pkg::PH_R2_TAIL:
        if (t >= int'(cfg.pres_sample) + int'(cfg.reset_tail))
          return ($urandom_range(0, 9) != 0);
      owtp_pkg::PH_RD_LO: begin
        if (bus_bits[b] == 0 && t == 0) all_ones_read[b] = ($urandom_range(0, 3) == 0);
        if (all_ones_read[b]) return 1'b1;
      end
      owtp_pkg::PH_RD_HI:
        if (all_ones_read[b]) return 1'b1;
      default: ;
    endcase
    return logic'($urandom_range(0, 1));
  endfunction

  task automatic send_tick(int b, bit healthy, int forced_lvl = -1);
    int gap;
    logic lvl;
    gap = (idle_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0;
    repeat (gap) begin
      @(negedge clk);
      in_ch.valid <= 0;
    end
    @(negedge clk);
    if (forced_lvl >= 0) lvl = forced_lvl[0];
    else lvl = healthy ? sensor_level(b) : logic'($urandom_range(0, 1));
    in_ch.valid <= 1;
    in_ch.bus <= b[0];
    in_ch.line_level <= lvl;
    do @(posedge clk); while (!in_ch.ready);
    expected_ticks.push_back(poll_tick(b, lvl));
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_ch.valid <= 0;
    while (expected_ticks.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [owtp_pkg::CFG_IDX_W-1:0] idx,
                           logic [owtp_pkg::CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      owtp_pkg::REG_CONV_WAIT: cfg.conv_wait = val;
      owtp_pkg::REG_RESET_LOW: cfg.reset_low = val[9:0];
      owtp_pkg::REG_PRES_SAMPLE: cfg.pres_sample = val[7:0];
      default: cfg.reset_tail = val[9:0];
    endcase
    @(negedge clk);
    cfg_we <= 0;
  endtask

  task automatic set_timing(int cw, int rl, int ps, int rt);
    wait_idle();
    write_reg(owtp_pkg::REG_CONV_WAIT, 20'(cw));
    write_reg(owtp_pkg::REG_RESET_LOW, 20'(rl));
    write_reg(owtp_pkg::REG_PRES_SAMPLE, 20'(ps));
    write_reg(owtp_pkg::REG_RESET_TAIL, 20'(rt));
  endtask

  task automatic run_readings(int per_bus, int max_ticks);
    int b;
    int n;
    int goal [2];
    goal[0] = readings_done[0] + per_bus;
    goal[1] = readings_done[1] + per_bus;
    n = 0;
    while ((readings_done[0] < goal[0] || readings_done[1] < goal[1]) && n < max_ticks) begin
      b = $urandom_range(0, 1);
      if (readings_done[b] >= goal[b]) b = 1 - b;
      send_tick(b, 1);
      n++;
    end
  endtask

  task automatic test_reset_defaults();
    for (int i = 0; i < 12; i++) send_tick(i % 2, 0, (i / 2) % 2);
  endtask

  task automatic test_zero_timing();
    set_timing(0, 0, 0, 0);
    // presence fail, then tail fail, on each bus
    for (int b = 0; b < 2; b++) begin
      send_tick(b, 0, 0);
      send_tick(b, 0, 1);
      send_tick(b, 0, 0);
      send_tick(b, 0, 0);
      send_tick(b, 0, 0);
    end
    run_readings(1, 60);
  endtask

  task automatic test_max_timing();
    set_timing(20'hFFFFF, 10'h3FF, 8'hFF, 10'h3FF);
    for (int i = 0; i < 10; i++) send_tick($urandom_range(0, 1), 0);
  endtask

  task automatic test_random_ticks();
    set_timing($urandom_range(1, 8), $urandom_range(1, 6), $urandom_range(0, 4),
               $urandom_range(1, 4));
    for (int i = 0; i < 150; i++) send_tick($urandom_range(0, 1), $urandom_range(0, 1));
  endtask

  task automatic test_readings();
    for (int k = 0; k < 3; k++) begin
      set_timing($urandom_range(1, 40), $urandom_range(1, 10), $urandom_range(0, 6),
                 $urandom_range(1, 6));
      run_readings(2, 40);
    end
  endtask

  task automatic test_backpressure();
    rx_hold = 300;
    for (int i = 0; i < 120; i++) send_tick($urandom_range(0, 1), 1);
    wait_idle();
    for (int i = 0; i < 30; i++) send_tick($urandom_range(0, 1), 1);
  endtask

  task automatic test_no_idle();
    idle_on = 0;
    set_timing(3, 2, 1, 2);
    run_readings(2, 50);
  endtask

  // result sink
  initial begin
    int burst;
    burst = 0;
    out_ch.ready = 0;
    forever begin
      @(negedge clk);
      if (rx_hold > 0) begin
        rx_hold--;
        out_ch.ready <= 0;
      end else begin
        if (idle_on && burst == 0 && $urandom_range(0, 3) == 0) burst = $urandom_range(1, 6);
        if (burst > 0) begin
          burst--;
          out_ch.ready <= 0;
        end else begin
          out_ch.ready <= 1;
        end
      end
    end
  end

  always @(posedge clk) begin
    tick_res_t e;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (expected_ticks.size() == 0) begin
        $error("unexpected result");
        errors++;
      end else begin
        e = expected_ticks.pop_front();
        if (out_ch.drive_low !== e.drive_low) begin
          $error("drive_low exp %0d got %0d", e.drive_low, out_ch.drive_low); errors++;
        end
        if (out_ch.reading_done !== e.reading_done) begin
          $error("reading_done exp %0d got %0d", e.reading_done, out_ch.reading_done);
          errors++;
        end
        if (out_ch.reading_valid !== e.reading_valid) begin
          $error("reading_valid exp %0d got %0d", e.reading_valid, out_ch.reading_valid);
          errors++;
        end
        if (out_ch.temp_value !== e.temp_value) begin
          $error("temp_value exp %0h got %0h", e.temp_value, out_ch.temp_value); errors++;
        end
      end
    end
  end

  initial begin
    errors = 0;
    idle_on = 1;
    rx_hold = 0;
    rst = 1;
    cfg_we = 0;
    cfg_index = '0;
    cfg_data = '0;
    in_ch.valid = 0;
    in_ch.bus = 0;
    in_ch.line_level = 0;
    cfg = {owtp_pkg::CONV_WAIT_RST, owtp_pkg::RESET_LOW_RST, owtp_pkg::PRES_SAMPLE_RST,
           owtp_pkg::RESET_TAIL_RST};
    for (int b = 0; b < 2; b++) begin
      enter_phase(b, owtp_pkg::PH_R1_LOW, 8'h00);
      bus_low[b] = '0;
      bus_rd_valid[b] = 0;
      bus_rd_value[b] = '0;
      all_ones_read[b] = 0;
      readings_done[b] = 0;
    end
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 0;

    test_reset_defaults();
    test_zero_timing();
    test_max_timing();
    test_random_ticks();
    test_readings();
    test_backpressure();
    test_no_idle();
    wait_idle();

    if (errors == 0) $display("PASS onewire_temp_sensor_poller_core");
    else $display("FAIL onewire_temp_sensor_poller_core");
    $finish;
  end

endmodule
